// ===== design/cihtl_pkg.sv =====
// Shared types and constants for the card number hash table lookup block.
// Holds the slot layout, status codes, operation codes and the hash step.
// No dependencies.
package cihtl_pkg;

  // Default geometry of the table.
  localparam int unsigned BucketsDefault = 4096;
  localparam int unsigned WaysDefault    = 4;

  // Key and answer widths.
  localparam int unsigned KeyW    = 96;
  localparam int unsigned AnswerW = 8;

  // Hash multiplier and the reply given when no stored answer applies.
  localparam logic [31:0]        HashMul   = 32'd13;
  localparam logic [AnswerW-1:0] MissReply = 8'h35;

  // Operation codes carried on the func port.
  localparam logic FuncLookup = 1'b0;
  localparam logic FuncInsert = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // One slot of a bucket row.
  typedef struct packed {
    logic               valid;
    logic [KeyW-1:0]    key;
    logic [AnswerW-1:0] answer;
  } slot_t;

  // One hash step: add the byte, then multiply by 13 with 32-bit wrap.
  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = h + {24'd0, b};
    return t * HashMul;
  endfunction

endpackage

// ===== design/card_id_hash_table_lookup.sv =====
// Top level of the card number hash table lookup block.
// Depends on cihtl_pkg for the slot layout, status codes and hash step.
// Holds the bucket memory, hash and remainder units and the control sequencer.
//
// Usage:
//   Command channel: an item (func_i, key_high_i, key_low_i, answer_in_i) is
//   taken at a rising edge where start is high and busy is low. func_i selects
//   a lookup or an insert-or-update of the 12-character key.
//   Result channel: done_o is high for exactly one cycle with status_o and
//   reply_o; the result is taken at the edge that ends that cycle. The
//   receiver cannot stall, so no result ever waits.
// Sequence:
//   The hash takes four key bytes per cycle. When Buckets is a power of two
//   the bucket is the low hash bits; otherwise a remainder unit then takes
//   four hash bits per cycle. Then the bucket row is read, the ways are
//   compared, and the row is written back and the result presented. No new
//   item is taken while one is in flight; the next item is taken in the
//   cycle done_o is high. The bucket memory has one write port and one
//   registered read port; each item reads its row once and writes it back
//   at most once, one at a time.
// Reset:
//   After reset a clearing pass writes empty rows to all Buckets rows, one per
//   cycle; busy stays high until the pass ends.
module card_id_hash_table_lookup
  import cihtl_pkg::*;
#(
  parameter int unsigned Buckets = BucketsDefault,
  parameter int unsigned Ways    = WaysDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic [31:0]        key_high_i,
  input  logic [63:0]        key_low_i,
  input  logic [AnswerW-1:0] answer_in_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [AnswerW-1:0] reply_o
);

  localparam int unsigned BktW   = $clog2(Buckets);
  localparam int unsigned RemW   = BktW + 1;
  localparam int unsigned WayW   = (Ways > 1) ? $clog2(Ways) : 1;
  localparam bit          IsPow2 = ((1 << BktW) == Buckets);
  localparam logic [RemW-1:0] BucketsR  = RemW'(Buckets);
  localparam logic [BktW-1:0] LastRow   = BktW'(Buckets - 1);

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_MOD   = 7'b0001000,
    S_READ  = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_WRITE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Control registers.
  logic [BktW-1:0] clr_q, clr_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            done_q, done_d;

  // Item and working registers.
  logic               func_q, func_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [AnswerW-1:0] ans_q, ans_d;
  logic [31:0]        hash_q, hash_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic               hit_q, hit_d;
  logic               free_q, free_d;
  logic [WayW-1:0]    match_idx_q, match_idx_d;
  logic [WayW-1:0]    free_idx_q, free_idx_d;
  logic [2:0]         status_q, status_d;
  logic [AnswerW-1:0] reply_q, reply_d;

  // Bucket memory and its port.
  slot_t [Ways-1:0] tbl_mem [Buckets];
  slot_t [Ways-1:0] rd_row_q;
  slot_t [Ways-1:0] wr_row;
  logic             mem_we;
  logic [BktW-1:0]  mem_waddr;
  logic [BktW-1:0]  mem_raddr;

  // Datapath helpers.
  logic [31:0]     key_chunk;
  logic [31:0]     hash_next;
  logic [RemW-1:0] rem_next;
  logic [31:0]     hash_shift;

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign reply_o  = reply_q;

  assign mem_raddr = rem_q[BktW-1:0];

  // Four key bytes of this hash cycle, first character first.
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    key_chunk = key_q[95:64];
      2'd1:    key_chunk = key_q[63:32];
      default: key_chunk = key_q[31:0];
    endcase
  end

  // Four hash steps per cycle.
  always_comb begin
    hash_next = hash_q;
    for (int i = 3; i >= 0; i--) begin
      hash_next = hash_step(hash_next, key_chunk[8*i +: 8]);
    end
  end

  // Restoring remainder, four hash bits per cycle, most significant first.
  always_comb begin
    rem_next   = rem_q;
    hash_shift = hash_q;
    for (int i = 0; i < 4; i++) begin
      rem_next   = {rem_next[BktW-1:0], hash_shift[31]};
      hash_shift = {hash_shift[30:0], 1'b0};
      if (rem_next >= BucketsR) begin
        rem_next = rem_next - BucketsR;
      end
    end
  end

  // Way compare on the bucket row just read; lowest way wins.
  always_comb begin
    hit_d       = hit_q;
    free_d      = free_q;
    match_idx_d = match_idx_q;
    free_idx_d  = free_idx_q;
    if (state_q == S_CMP) begin
      hit_d       = 1'b0;
      free_d      = 1'b0;
      match_idx_d = '0;
      free_idx_d  = '0;
      for (int w = Ways - 1; w >= 0; w--) begin
        if (rd_row_q[w].valid && (rd_row_q[w].key == key_q)) begin
          hit_d       = 1'b1;
          match_idx_d = WayW'(w);
        end
        if (!rd_row_q[w].valid) begin
          free_d     = 1'b1;
          free_idx_d = WayW'(w);
        end
      end
    end
  end

  // Sequencer and result formation.
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    func_d   = func_q;
    key_d    = key_q;
    ans_d    = ans_q;
    hash_d   = hash_q;
    rem_d    = rem_q;
    status_d = status_q;
    reply_d  = reply_q;
    mem_we   = 1'b0;
    mem_waddr = rem_q[BktW-1:0];
    wr_row   = rd_row_q;

    unique case (state_q)
      // Write empty rows through the whole memory after reset.
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        wr_row    = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastRow) begin
          state_d = S_IDLE;
        end
      end
      // Capture the command beat.
      S_IDLE: begin
        if (start) begin
          func_d  = func_i;
          key_d   = {key_high_i, key_low_i};
          ans_d   = answer_in_i;
          hash_d  = '0;
          cnt_d   = '0;
          state_d = S_HASH;
        end
      end
      // Hash four bytes per cycle over the whole 12-byte key.
      S_HASH: begin
        hash_d = hash_next;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == 3'd2) begin
          cnt_d = '0;
          if (IsPow2) begin
            rem_d   = {1'b0, hash_next[BktW-1:0]};
            state_d = S_READ;
          end else begin
            rem_d   = '0;
            state_d = S_MOD;
          end
        end
      end
      // Reduce the hash modulo the bucket count.
      S_MOD: begin
        rem_d  = rem_next;
        hash_d = hash_shift;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == 3'd7) begin
          state_d = S_READ;
        end
      end
      // Bucket row read is in flight.
      S_READ: begin
        state_d = S_CMP;
      end
      // Ways are compared into hit and free registers.
      S_CMP: begin
        state_d = S_WRITE;
      end
      // Decide, write back the row and present the result.
      S_WRITE: begin
        done_d  = 1'b1;
        reply_d = MissReply;
        state_d = S_IDLE;
        if (func_q == FuncLookup) begin
          if (hit_q) begin
            status_d = ST_HIT;
            reply_d  = rd_row_q[match_idx_q].answer;
          end else begin
            status_d = ST_MISS;
          end
        end else if (hit_q) begin
          status_d                    = ST_UPDATED;
          wr_row[match_idx_q].answer  = ans_q;
          mem_we                      = 1'b1;
        end else if (free_q) begin
          status_d                   = ST_INSERTED;
          wr_row[free_idx_q].valid   = 1'b1;
          wr_row[free_idx_q].key     = key_q;
          wr_row[free_idx_q].answer  = ans_q;
          mem_we                     = 1'b1;
        end else begin
          status_d = ST_FULL;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    key_q       <= key_d;
    ans_q       <= ans_d;
    hash_q      <= hash_d;
    rem_q       <= rem_d;
    hit_q       <= hit_d;
    free_q      <= free_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    status_q    <= status_d;
    reply_q     <= reply_d;
  end

  // Bucket memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= wr_row;
    end
    rd_row_q <= tbl_mem[mem_raddr];
  end

endmodule
